// File: hdl/qte_pkg.sv
// Shared types, constants and arctangent table for the quaternion to Euler unit.
package qte_pkg;

  localparam int MAX_STEPS = 24;
  localparam int VW = 36;
  localparam int AW = 28;

  localparam logic signed [AW-1:0] PI_HALF_Q24 = 28'sd26353589;
  localparam logic signed [17:0] PI_Q13 = 18'sd25736;
  localparam logic signed [17:0] PI_HALF_Q13 = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

  localparam logic [1:0] POLE_NONE = 2'd0;
  localparam logic [1:0] POLE_NORTH = 2'd1;
  localparam logic [1:0] POLE_SOUTH = 2'd2;

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [AW-1:0] ang_t;

  function automatic ang_t atan_entry(input int i);
    ang_t t;
    unique case (i)
      0: t = 28'sd13176795;
      1: t = 28'sd7778716;
      2: t = 28'sd4110060;
      3: t = 28'sd2086331;
      4: t = 28'sd1047214;
      5: t = 28'sd524117;
      6: t = 28'sd262123;
      7: t = 28'sd131069;
      default: t = ang_t'(28'sd1 <<< (24 - i));
    endcase
    return t;
  endfunction

  // Rounds a Q.24 angle to Q.13, ties away from zero.
  function automatic logic signed [17:0] round_q13(input logic signed [AW:0] v);
    logic [AW:0] m;
    logic [AW:0] r;
    m = v[AW] ? (AW+1)'(0) - v : v;
    r = (m + (AW+1)'(1024)) >> 11;
    return v[AW] ? 18'sd0 - $signed(r[17:0]) : $signed(r[17:0]);
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [17:0] v,
                                               input logic signed [17:0] lim);
    logic signed [17:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

endpackage

// File: hdl/qte_cordic.sv
// Pipelined vectoring CORDIC computing atan2 with one micro-rotation per stage.
module qte_cordic import qte_pkg::*; #(
  parameter int STEPS = 16,
  parameter int TW = 4
) (
  input  logic           clk,
  input  logic           en,
  input  vec_t           y_i,
  input  vec_t           x_i,
  input  logic [TW-1:0]  tag_i,
  output ang_t           z_o,
  output logic [TW-1:0]  tag_o
);

  vec_t          x_r [STEPS+1];
  vec_t          y_r [STEPS+1];
  ang_t          z_r [STEPS+1];
  logic          zero_r [STEPS+1];
  logic [TW-1:0] tag_r [STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_i == '0) && (y_i == '0);
      tag_r[0] <= tag_i;
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_r[0] <= y_i; y_r[0] <= -x_i; z_r[0] <= PI_HALF_Q24;
        end else begin
          x_r[0] <= -y_i; y_r[0] <= x_i; z_r[0] <= -PI_HALF_Q24;
        end
      end else begin
        x_r[0] <= x_i; y_r[0] <= y_i; z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        tag_r[i+1] <= tag_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_entry(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_entry(i);
        end
      end
    end
  end

  assign z_o = zero_r[STEPS] ? '0 : z_r[STEPS];
  assign tag_o = tag_r[STEPS];

endmodule

// File: hdl/qte_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module qte_isqrt import qte_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [56:0] v_i,
  input  vec_t        s_i,
  output logic [28:0] r_o,
  output vec_t        s_o
);

  localparam int N = 29;

  logic [57:0] rem_r [N+1];
  logic [57:0] res_r [N+1];
  vec_t        s_r [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, v_i};
      res_r[0] <= '0;
      s_r[0] <= s_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_bit
    localparam logic [57:0] BIT = 58'd1 << (2 * (N - 1 - i));
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i+1] <= s_r[i];
        if (rem_r[i] >= res_r[i] + BIT) begin
          rem_r[i+1] <= rem_r[i] - (res_r[i] + BIT);
          res_r[i+1] <= (res_r[i] >> 1) + BIT;
        end else begin
          rem_r[i+1] <= rem_r[i];
          res_r[i+1] <= res_r[i] >> 1;
        end
      end
    end
  end

  assign r_o = res_r[N][28:0];
  assign s_o = s_r[N];

endmodule

// File: hdl/quaternion_to_euler_unit.sv
// Top level of the pipelined quaternion to Euler angle converter.
//  channel | direction | transfer condition
//  in_     | in        | in_tvalid && in_tready
//  out_    | out       | out_tvalid && out_tready
//  cfg_    | in        | cfg_valid && cfg_ready
// The pipeline holds three arithmetic stages, 30 square root stages,
// CORDIC_STEPS + 1 CORDIC stages and the output register.
// One quaternion is accepted every cycle while the output is taken.
// A stall freezes the whole pipeline; an output skid register parts the sides.
// Reset clears the valid bits and loads the default pole threshold.
module quaternion_to_euler_unit import qte_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // qx, qy, qz, qw
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // pitch_angle, yaw_angle, roll_angle, zero fill
  output logic [1:0]  out_tuser,  // pole_case
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_tdata
);

  localparam int LAT = 3 + 30 + CORDIC_STEPS + 2;

  logic [14:0] thr_r;
  logic [LAT-1:0] vld_r;
  logic en;
  logic skid_vld_r;
  logic [55:0] skid_data_r;
  logic [1:0] skid_user_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= 15'd8176;
    else if (cfg_valid) thr_r <= cfg_tdata;
  end

  // Stage 1: products
  logic signed [15:0] qx, qy, qz, qw;
  assign qx = in_tdata[15:0];
  assign qy = in_tdata[31:16];
  assign qz = in_tdata[47:32];
  assign qw = in_tdata[63:48];

  logic signed [31:0] xy_r, zw_r, yw_r, xz_r, yy_r, zz_r, xw_r, yz_r, xx_r;
  logic signed [15:0] x1_r, w1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xy_r <= qx * qy; zw_r <= qz * qw; yw_r <= qy * qw; xz_r <= qx * qz;
      yy_r <= qy * qy; zz_r <= qz * qz; xw_r <= qx * qw; yz_r <= qy * qz;
      xx_r <= qx * qx; x1_r <= qx; w1_r <= qw;
    end
  end

  // Stage 2: sums, pole decision
  vec_t test_r, ry_r, rx_r, yy2_r, yx_r, px_r, pw_r;
  logic [1:0] pole2_r;
  vec_t test_w, thr_w;
  assign test_w = VW'(xy_r) + VW'(zw_r);
  assign thr_w = VW'({thr_r, 14'd0});
  always_ff @(posedge clk) begin
    if (en) begin
      test_r <= test_w;
      ry_r <= (VW'(yw_r) - VW'(xz_r)) <<< 1;
      rx_r <= (VW'(1) <<< 28) - (VW'(yy_r) <<< 1) - (VW'(zz_r) <<< 1);
      yy2_r <= (VW'(xw_r) - VW'(yz_r)) <<< 1;
      yx_r <= (VW'(1) <<< 28) - (VW'(xx_r) <<< 1) - (VW'(zz_r) <<< 1);
      px_r <= VW'(x1_r) <<< 14;
      pw_r <= VW'(w1_r) <<< 14;
      if (test_w > thr_w) pole2_r <= POLE_NORTH;
      else if (test_w < -thr_w) pole2_r <= POLE_SOUTH;
      else pole2_r <= POLE_NONE;
    end
  end

  // Stage 3: clamp asin argument, square
  vec_t s3_r, s3_w;
  vec_t ry3_r, rx3_r, yy3_r, yx3_r, px3_r, pw3_r;
  logic [1:0] pole3_r;
  always_comb begin
    s3_w = test_r <<< 1;
    if (s3_w > (VW'(1) <<< 28)) s3_w = VW'(1) <<< 28;
    else if (s3_w < -(VW'(1) <<< 28)) s3_w = -(VW'(1) <<< 28);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_w;
      ry3_r <= ry_r; rx3_r <= rx_r; yy3_r <= yy2_r; yx3_r <= yx_r;
      px3_r <= px_r; pw3_r <= pw_r; pole3_r <= pole2_r;
    end
  end

  // s is within plus or minus 2^28, so its low 29 bits as magnitude need care.
  logic [28:0] s_mag;
  assign s_mag = s3_w[VW-1] ? 29'(-s3_w) : s3_w[28:0];
  logic [56:0] sq_w;
  logic [56:0] sq3b_r;
  always_ff @(posedge clk) if (en) sq3b_r <= 57'(s_mag * s_mag);
  assign sq_w = (57'd1 << 56) - sq3b_r;

  // Delay the other operands across the square root.
  localparam int DS = 30;
  vec_t dry_r [DS], drx_r [DS], dyy_r [DS], dyx_r [DS], dpx_r [DS], dpw_r [DS];
  logic [1:0] dpole_r [DS];
  always_ff @(posedge clk) begin
    if (en) begin
      dry_r[0] <= ry3_r; drx_r[0] <= rx3_r; dyy_r[0] <= yy3_r; dyx_r[0] <= yx3_r;
      dpx_r[0] <= px3_r; dpw_r[0] <= pw3_r; dpole_r[0] <= pole3_r;
      for (int i = 1; i < DS; i++) begin
        dry_r[i] <= dry_r[i-1]; drx_r[i] <= drx_r[i-1];
        dyy_r[i] <= dyy_r[i-1]; dyx_r[i] <= dyx_r[i-1];
        dpx_r[i] <= dpx_r[i-1]; dpw_r[i] <= dpw_r[i-1];
        dpole_r[i] <= dpole_r[i-1];
      end
    end
  end

  logic [28:0] c_w;
  vec_t s_w;
  qte_isqrt u_sqrt (.clk, .en, .v_i(sq_w), .s_i(s3_r), .r_o(c_w), .s_o(s_w));

  // The delay lines match the 30 register stages of the square root.
  logic pole_sel;
  assign pole_sel = dpole_r[DS-1] != POLE_NONE;

  ang_t za, zb, zc;
  logic [1:0] pa, pb, pc;
  qte_cordic #(.STEPS(CORDIC_STEPS), .TW(2)) u_roll (
    .clk, .en,
    .y_i(pole_sel ? dpx_r[DS-1] : dry_r[DS-1]),
    .x_i(pole_sel ? dpw_r[DS-1] : drx_r[DS-1]),
    .tag_i(dpole_r[DS-1]), .z_o(za), .tag_o(pa));
  qte_cordic #(.STEPS(CORDIC_STEPS), .TW(2)) u_yaw (
    .clk, .en, .y_i(dyy_r[DS-1]), .x_i(dyx_r[DS-1]),
    .tag_i(POLE_NONE), .z_o(zb), .tag_o(pb));
  qte_cordic #(.STEPS(CORDIC_STEPS), .TW(2)) u_pitch (
    .clk, .en, .y_i(s_w), .x_i(VW'(c_w)),
    .tag_i(POLE_NONE), .z_o(zc), .tag_o(pc));

  // Final stage: round and saturate.
  logic signed [17:0] roll_w, yaw_w, pitch_w;
  always_comb begin
    unique case (pa)
      POLE_NORTH: begin
        roll_w = sat18(round_q13({za, 1'b0}), TWO_PI_Q13);
        pitch_w = PI_HALF_Q13; yaw_w = '0;
      end
      POLE_SOUTH: begin
        roll_w = sat18(round_q13(-{za[AW-1], za}  <<< 1), TWO_PI_Q13);
        pitch_w = -PI_HALF_Q13; yaw_w = '0;
      end
      default: begin
        roll_w = sat18(round_q13({za[AW-1], za}), PI_Q13);
        yaw_w = sat18(round_q13({zb[AW-1], zb}), PI_Q13);
        pitch_w = sat18(round_q13({zc[AW-1], zc}), PI_HALF_Q13);
      end
    endcase
  end

  logic [55:0] res_r;
  logic [1:0] pole_r;
  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= {8'd0, roll_w[16:0], yaw_w[15:0], pitch_w[14:0]};
      pole_r <= pa ^ pb ^ pc;
    end
  end

  // Valid chain, stall control and skid register.
  logic out_full;
  assign out_full = vld_r[LAT-1];
  assign en = !skid_vld_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      skid_vld_r <= 1'b0;
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
      if (!skid_vld_r && out_full && !out_tready) skid_vld_r <= 1'b1;
      else if (skid_vld_r && out_tready) skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r) begin
      skid_data_r <= res_r;
      skid_user_r <= pole_r;
    end
  end

  assign out_tvalid = skid_vld_r || out_full;
  assign out_tdata = skid_vld_r ? skid_data_r : res_r;
  assign out_tuser = skid_vld_r ? skid_user_r : pole_r;

endmodule
